// ----- src/kmc_pkg.sv -----
`timescale 1ns / 1ps

package kmc_pkg;

    localparam int SLOT_WIDTH  = 10;
    localparam int FUNC_WIDTH  = 2;
    localparam int ADDR_WIDTH  = 4;
    localparam int DATA_WIDTH  = 32;
    localparam int PCOUNT_W    = 11;
    localparam int CCOUNT_W    = 5;
    localparam int ITER_W      = 16;

    localparam logic [FUNC_WIDTH-1:0] FUNC_LOAD_POINT  = 2'd0;
    localparam logic [FUNC_WIDTH-1:0] FUNC_LOAD_CENTER = 2'd1;
    localparam logic [FUNC_WIDTH-1:0] FUNC_RUN         = 2'd2;
    localparam logic [FUNC_WIDTH-1:0] FUNC_READ        = 2'd3;

    localparam logic [1:0] REG_POINT_COUNT    = 2'd0;
    localparam logic [1:0] REG_CENTER_COUNT   = 2'd1;
    localparam logic [1:0] REG_MAX_ITERATIONS = 2'd2;

    localparam logic [PCOUNT_W-1:0] POINT_COUNT_RST    = 11'd1024;
    localparam logic [CCOUNT_W-1:0] CENTER_COUNT_RST   = 5'd16;
    localparam logic [ITER_W-1:0]   MAX_ITERATIONS_RST = 16'd100;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ----- src/kmc_divider.sv -----
`timescale 1ns / 1ps

module kmc_divider #(
    parameter int DVD_W = 27,
    parameter int DVS_W = 11,
    parameter int Q_W   = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [DVD_W-1:0] dividend,
    input  logic        [DVS_W-1:0] divisor,
    output logic        [Q_W-1:0]   quotient,
    output kmc_pkg::div_stat_t      stat
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] mag_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             neg_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DVS_W:0]   trial;
    logic             qbit;
    logic [DVD_W-1:0] signed_q;

    assign trial    = {rem_reg, mag_reg[DVD_W-1]};
    assign qbit     = (trial >= {1'b0, dvs_reg});
    assign signed_q = neg_reg ? (~mag_reg + 1'b1) : mag_reg;
    assign quotient = signed_q[Q_W-1:0];
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mag_reg  <= '0;
            rem_reg  <= '0;
            dvs_reg  <= '0;
            cnt_reg  <= '0;
            neg_reg  <= 1'b0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                mag_reg  <= dividend[DVD_W-1] ? (~dividend + 1'b1) : dividend;
                neg_reg  <= dividend[DVD_W-1];
                dvs_reg  <= divisor;
                rem_reg  <= '0;
                cnt_reg  <= CNT_W'(DVD_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg <= qbit ? DVS_W'(trial - {1'b0, dvs_reg}) : trial[DVS_W-1:0];
                mag_reg <= {mag_reg[DVD_W-2:0], qbit};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

// ----- src/kmeans_2d_clustering_unit.sv -----
`timescale 1ns / 1ps
// channel   dir  handshake                      word
// config    in   psel/penable/pwrite, pready=1  point_count, center_count, max_iterations
// command   in   start while busy low           func, slot, coord_x, coord_y
// result    out  done strobe, one cycle         cluster, iterations_done, is_run_result
// Loads finish while the unit stays idle, back to back. A read passes S_RD, which registers done.
// A run first clears the assignments of all MAX_POINTS slots; each pass then sends
// every point through the shared squarer for each centre and divides the SW-bit sums
// of each non-empty centre in the serial divider, SW = COORD_WIDTH+log2(MAX_POINTS)+1.
// Reset is asynchronous; results cannot be stalled.

module kmeans_2d_clustering_unit #(
    parameter int MAX_POINTS  = 1024,
    parameter int MAX_CENTERS = 16,
    parameter int COORD_WIDTH = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [kmc_pkg::ADDR_WIDTH-1:0]       paddr,
    input  logic [kmc_pkg::DATA_WIDTH-1:0]       pwdata,
    output logic [kmc_pkg::DATA_WIDTH-1:0]       prdata,
    output logic                                 pready,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [kmc_pkg::FUNC_WIDTH-1:0]       func,
    input  logic [kmc_pkg::SLOT_WIDTH-1:0]       slot,
    input  logic signed [COORD_WIDTH-1:0]        coord_x,
    input  logic signed [COORD_WIDTH-1:0]        coord_y,
    output logic                                 done,
    output logic [$clog2(MAX_CENTERS)-1:0]       cluster,
    output logic [kmc_pkg::ITER_W-1:0]           iterations_done,
    output logic                                 is_run_result
);

    localparam int PW  = $clog2(MAX_POINTS);
    localparam int PCW = $clog2(MAX_POINTS + 1);
    localparam int CW  = $clog2(MAX_CENTERS);
    localparam int NCW = $clog2(MAX_CENTERS + 1);
    localparam int SW  = COORD_WIDTH + PW + 1;
    localparam int DFW = COORD_WIDTH + 1;
    localparam int SQW = 2 * DFW;
    localparam int DW  = SQW + 1;
    localparam int IW  = kmc_pkg::ITER_W;

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_CLEAR, S_PASS, S_PT, S_DX, S_DY, S_CMP,
        S_ACC, S_UPD, S_DIVX, S_DIVY, S_END
    } state_t;

    state_t state_reg;

    logic [kmc_pkg::PCOUNT_W-1:0] point_count_reg;
    logic [kmc_pkg::CCOUNT_W-1:0] center_count_reg;
    logic [IW-1:0]                max_iter_reg;

    logic [2*COORD_WIDTH-1:0] pt_mem [MAX_POINTS];
    logic [CW-1:0]            asg_mem [MAX_POINTS];
    logic [2*COORD_WIDTH-1:0] pt_q_reg;
    logic [CW-1:0]            asg_q_reg;

    logic signed [COORD_WIDTH-1:0] cx_reg [MAX_CENTERS];
    logic signed [COORD_WIDTH-1:0] cy_reg [MAX_CENTERS];
    logic signed [SW-1:0]          sum_x_reg [MAX_CENTERS];
    logic signed [SW-1:0]          sum_y_reg [MAX_CENTERS];
    logic [PCW-1:0]                cnt_reg [MAX_CENTERS];

    logic [PCW-1:0] p_reg;
    logic [PCW-1:0] np_reg;
    logic [NCW-1:0] c_reg;
    logic [NCW-1:0] nc_reg;
    logic [IW-1:0]  iter_reg;
    logic [DW-1:0]  best_reg;
    logic [CW-1:0]  bc_reg;
    logic [SQW-1:0] sq_reg;
    logic [SQW-1:0] dxsq_reg;
    logic           changed_reg;
    logic           ever_run_reg;
    logic           rd_inr_reg;

    logic                     done_reg;
    logic [CW-1:0]            cluster_reg;
    logic [IW-1:0]            iter_out_reg;
    logic                     is_run_reg;

    logic [31:0]   slot_ext;
    logic          slot_pt_ok;
    logic          slot_ctr_ok;
    logic [PW-1:0] slot_pidx;
    logic [CW-1:0] slot_cidx;
    logic [PW-1:0] p_idx;
    logic [CW-1:0] c_idx;
    logic          accept;
    logic          cfg_wr;

    logic signed [COORD_WIDTH-1:0] px;
    logic signed [COORD_WIDTH-1:0] py;
    logic signed [DFW-1:0]         diff;
    logic signed [SQW-1:0]         sq;
    logic [DW-1:0]                 dist_sum;
    logic                          last_c;

    logic                     pt_we;
    logic                     asg_we;
    logic [PW-1:0]            asg_waddr;
    logic [CW-1:0]            asg_wdata;
    logic [PW-1:0]            asg_raddr;

    logic                     div_start;
    logic signed [SW-1:0]     div_dvd;
    logic [COORD_WIDTH-1:0]   div_q;
    kmc_pkg::div_stat_t       div_stat;

    logic                     cx_we;
    logic                     cy_we;
    logic [CW-1:0]            cw_idx;
    logic [COORD_WIDTH-1:0]   cx_wd;
    logic [COORD_WIDTH-1:0]   cy_wd;

    logic [31:0] np_calc;
    logic [31:0] nc_calc;

    assign accept      = start && (state_reg == S_IDLE);
    assign busy        = (state_reg != S_IDLE);
    assign slot_ext    = 32'(slot);
    assign slot_pt_ok  = (slot_ext < 32'(MAX_POINTS));
    assign slot_ctr_ok = (slot_ext < 32'(MAX_CENTERS));
    assign slot_pidx   = slot_ext[PW-1:0];
    assign slot_cidx   = slot_ext[CW-1:0];
    assign p_idx       = p_reg[PW-1:0];
    assign c_idx       = c_reg[CW-1:0];
    assign last_c      = (c_reg == nc_reg - 1'b1);

    assign np_calc = (32'(point_count_reg) > 32'(MAX_POINTS)) ? 32'(MAX_POINTS)
                                                            : 32'(point_count_reg);
    assign nc_calc = (center_count_reg == '0) ? 32'd1 :
                     (32'(center_count_reg) > 32'(MAX_CENTERS)) ? 32'(MAX_CENTERS)
                                                               : 32'(center_count_reg);

    assign px   = signed'(pt_q_reg[2*COORD_WIDTH-1:COORD_WIDTH]);
    assign py   = signed'(pt_q_reg[COORD_WIDTH-1:0]);
    assign diff = (state_reg == S_DX) ? (DFW'(px) - DFW'(cx_reg[c_idx]))
                                      : (DFW'(py) - DFW'(cy_reg[c_idx]));
    assign sq   = diff * diff;
    assign dist_sum = DW'(dxsq_reg) + DW'(sq_reg);

    // config port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        unique case (paddr[3:2])
            kmc_pkg::REG_POINT_COUNT:    prdata = 32'(point_count_reg);
            kmc_pkg::REG_CENTER_COUNT:   prdata = 32'(center_count_reg);
            kmc_pkg::REG_MAX_ITERATIONS: prdata = 32'(max_iter_reg);
            default:                     prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg  <= kmc_pkg::POINT_COUNT_RST;
            center_count_reg <= kmc_pkg::CENTER_COUNT_RST;
            max_iter_reg     <= kmc_pkg::MAX_ITERATIONS_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                kmc_pkg::REG_POINT_COUNT:
                    point_count_reg <= pwdata[kmc_pkg::PCOUNT_W-1:0];
                kmc_pkg::REG_CENTER_COUNT:
                    center_count_reg <= pwdata[kmc_pkg::CCOUNT_W-1:0];
                kmc_pkg::REG_MAX_ITERATIONS:
                    max_iter_reg <= pwdata[IW-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // memories
    assign pt_we     = accept && (func == kmc_pkg::FUNC_LOAD_POINT) && slot_pt_ok;
    assign asg_raddr = (state_reg == S_IDLE) ? slot_pidx : p_idx;
    assign asg_we    = (state_reg == S_CLEAR) ||
                       ((state_reg == S_ACC) && (asg_q_reg != bc_reg));
    assign asg_waddr = p_idx;
    assign asg_wdata = (state_reg == S_CLEAR) ? '0 : bc_reg;

    always_ff @(posedge clk)
    begin
        if (pt_we)
            pt_mem[slot_pidx] <= {coord_x, coord_y};
        pt_q_reg <= pt_mem[p_idx];
    end

    always_ff @(posedge clk)
    begin
        if (asg_we)
            asg_mem[asg_waddr] <= asg_wdata;
        asg_q_reg <= asg_mem[asg_raddr];
    end

    // centre store
    always_comb
    begin
        cx_we  = 1'b0;
        cy_we  = 1'b0;
        cw_idx = c_idx;
        cx_wd  = div_q;
        cy_wd  = div_q;
        if (accept && (func == kmc_pkg::FUNC_LOAD_CENTER) && slot_ctr_ok)
        begin
            cx_we  = 1'b1;
            cy_we  = 1'b1;
            cw_idx = slot_cidx;
            cx_wd  = coord_x;
            cy_wd  = coord_y;
        end
        else if ((state_reg == S_DIVX) && div_stat.done)
            cx_we = 1'b1;
        else if ((state_reg == S_DIVY) && div_stat.done)
            cy_we = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cx_we)
            cx_reg[cw_idx] <= signed'(cx_wd);
        if (cy_we)
            cy_reg[cw_idx] <= signed'(cy_wd);
    end

    // mean divider
    assign div_start = ((state_reg == S_UPD) && (cnt_reg[c_idx] != '0)) ||
                       ((state_reg == S_DIVX) && div_stat.done);
    assign div_dvd   = (state_reg == S_UPD) ? sum_x_reg[c_idx] : sum_y_reg[c_idx];

    kmc_divider #(
        .DVD_W (SW),
        .DVS_W (PCW),
        .Q_W   (COORD_WIDTH)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (cnt_reg[c_idx]),
        .quotient (div_q),
        .stat     (div_stat)
    );

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            p_reg        <= '0;
            np_reg       <= '0;
            c_reg        <= '0;
            nc_reg       <= '0;
            iter_reg     <= '0;
            best_reg     <= '0;
            bc_reg       <= '0;
            sq_reg       <= '0;
            dxsq_reg     <= '0;
            changed_reg  <= 1'b0;
            ever_run_reg <= 1'b0;
            rd_inr_reg   <= 1'b0;
            done_reg     <= 1'b0;
            cluster_reg  <= '0;
            iter_out_reg <= '0;
            is_run_reg   <= 1'b0;
            for (int i = 0; i < MAX_CENTERS; i++)
            begin
                sum_x_reg[i] <= '0;
                sum_y_reg[i] <= '0;
                cnt_reg[i]   <= '0;
            end
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept && (func == kmc_pkg::FUNC_READ))
                    begin
                        rd_inr_reg <= slot_pt_ok;
                        state_reg  <= S_RD;
                    end
                    else if (accept && (func == kmc_pkg::FUNC_RUN))
                    begin
                        ever_run_reg <= 1'b1;
                        np_reg       <= np_calc[PCW-1:0];
                        nc_reg       <= nc_calc[NCW-1:0];
                        p_reg        <= '0;
                        state_reg    <= S_CLEAR;
                    end
                end
                S_RD:
                begin
                    done_reg     <= 1'b1;
                    cluster_reg  <= (rd_inr_reg && ever_run_reg) ? asg_q_reg : '0;
                    iter_out_reg <= '0;
                    is_run_reg   <= 1'b0;
                    state_reg    <= S_IDLE;
                end
                S_CLEAR:
                begin
                    p_reg <= p_reg + 1'b1;
                    if (p_reg == PCW'(MAX_POINTS - 1))
                    begin
                        iter_reg <= '0;
                        if (max_iter_reg == '0)
                        begin
                            done_reg     <= 1'b1;
                            cluster_reg  <= '0;
                            iter_out_reg <= '0;
                            is_run_reg   <= 1'b1;
                            state_reg    <= S_IDLE;
                        end
                        else
                            state_reg <= S_PASS;
                    end
                end
                S_PASS:
                begin
                    changed_reg <= 1'b0;
                    p_reg       <= '0;
                    c_reg       <= '0;
                    for (int i = 0; i < MAX_CENTERS; i++)
                    begin
                        sum_x_reg[i] <= '0;
                        sum_y_reg[i] <= '0;
                        cnt_reg[i]   <= '0;
                    end
                    state_reg <= (np_reg == '0) ? S_UPD : S_PT;
                end
                S_PT:
                begin
                    c_reg     <= '0;
                    state_reg <= S_DX;
                end
                S_DX:
                begin
                    sq_reg    <= unsigned'(sq);
                    state_reg <= S_DY;
                end
                S_DY:
                begin
                    dxsq_reg  <= sq_reg;
                    sq_reg    <= unsigned'(sq);
                    state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    if ((c_reg == '0) || (dist_sum < best_reg))
                    begin
                        best_reg <= dist_sum;
                        bc_reg   <= c_idx;
                    end
                    if (last_c)
                        state_reg <= S_ACC;
                    else
                    begin
                        c_reg     <= c_reg + 1'b1;
                        state_reg <= S_DX;
                    end
                end
                S_ACC:
                begin
                    if (asg_q_reg != bc_reg)
                        changed_reg <= 1'b1;
                    sum_x_reg[bc_reg] <= sum_x_reg[bc_reg] + SW'(px);
                    sum_y_reg[bc_reg] <= sum_y_reg[bc_reg] + SW'(py);
                    cnt_reg[bc_reg]   <= cnt_reg[bc_reg] + 1'b1;
                    p_reg             <= p_reg + 1'b1;
                    if (p_reg + 1'b1 == np_reg)
                    begin
                        c_reg     <= '0;
                        state_reg <= S_UPD;
                    end
                    else
                        state_reg <= S_PT;
                end
                S_UPD:
                begin
                    if (cnt_reg[c_idx] != '0)
                        state_reg <= S_DIVX;
                    else if (last_c)
                        state_reg <= S_END;
                    else
                        c_reg <= c_reg + 1'b1;
                end
                S_DIVX:
                begin
                    if (div_stat.done)
                        state_reg <= S_DIVY;
                end
                S_DIVY:
                begin
                    if (div_stat.done)
                    begin
                        if (last_c)
                            state_reg <= S_END;
                        else
                        begin
                            c_reg     <= c_reg + 1'b1;
                            state_reg <= S_UPD;
                        end
                    end
                end
                S_END:
                begin
                    if (!changed_reg || (iter_reg + 1'b1 == max_iter_reg))
                    begin
                        done_reg     <= 1'b1;
                        cluster_reg  <= '0;
                        iter_out_reg <= changed_reg ? max_iter_reg : iter_reg;
                        is_run_reg   <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                    else
                    begin
                        iter_reg  <= iter_reg + 1'b1;
                        state_reg <= S_PASS;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign done            = done_reg;
    assign cluster         = cluster_reg;
    assign iterations_done = iter_out_reg;
    assign is_run_result   = is_run_reg;

endmodule

// ----- src/kmc_checker.sv -----
`timescale 1ns / 1ps

module kmc_checker #(
    parameter int CLW = 4
) (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            start,
    input logic                            busy,
    input logic [kmc_pkg::FUNC_WIDTH-1:0]  func,
    input logic                            done,
    input logic [CLW-1:0]                  cluster,
    input logic [kmc_pkg::ITER_W-1:0]      iterations_done,
    input logic                            is_run_result
);

    // word leaves only once the unit is free again
    a_done_free: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result word while busy");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result words back to back");

    a_load_quick: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (func == kmc_pkg::FUNC_LOAD_POINT ||
                            func == kmc_pkg::FUNC_LOAD_CENTER)) |=> (!busy && !done))
        else $error("load word did not complete in one cycle");

    a_cmd_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (func == kmc_pkg::FUNC_RUN ||
                            func == kmc_pkg::FUNC_READ)) |=> busy)
        else $error("run or read word not taken up");

    a_fields: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (is_run_result ? (cluster == '0) : (iterations_done == '0)))
        else $error("unused result field not zero");

endmodule

bind kmeans_2d_clustering_unit kmc_checker #(
    .CLW ($clog2(MAX_CENTERS))
) u_kmc_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .func            (func),
    .done            (done),
    .cluster         (cluster),
    .iterations_done (iterations_done),
    .is_run_result   (is_run_result)
);

// ----- tb/kmeans_2d_clustering_checker.sv -----
`timescale 1ns / 1ps

module kmeans_2d_clustering_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               pready,
    input  logic               start,
    input  logic               busy,
    input  logic [1:0]         func,
    input  logic [9:0]         slot,
    input  logic signed [15:0] coord_x,
    input  logic signed [15:0] coord_y,
    input  logic               done,
    input  logic [3:0]         cluster,
    input  logic [15:0]        iterations_done,
    input  logic               is_run_result,
    output int                 error_count,
    output int                 awaited
);

    localparam int NPTS = 1024;
    localparam int NCTR = 16;

    typedef struct {
        logic [3:0]  cluster;
        logic [15:0] iters;
        logic        is_run;
    } answer_t;

    shortint     pt_x [NPTS];
    shortint     pt_y [NPTS];
    logic [3:0]  owner [NPTS];
    shortint     ctr_x [NCTR];
    shortint     ctr_y [NCTR];
    logic [10:0] n_points;
    logic [4:0]  n_centres;
    logic [15:0] pass_limit;
    answer_t     answers [$];

    function automatic longint sq_dist(int p, int c);
        longint dx;
        longint dy;
        dx = longint'(pt_x[p]) - longint'(ctr_x[c]);
        dy = longint'(pt_y[p]) - longint'(ctr_y[c]);
        return dx * dx + dy * dy;
    endfunction

    // Lloyd passes; returns the pass index at which nothing moved, or pass_limit if points kept moving
    function automatic logic [15:0] cluster_points();
        int     np;
        int     nc;
        int     it;
        int     bc;
        int     members [NCTR];
        longint sum_x [NCTR];
        longint sum_y [NCTR];
        longint best;
        longint d;
        bit     moved;
        np = (n_points > NPTS) ? NPTS : n_points;
        nc = (n_centres == 0) ? 1 : ((n_centres > NCTR) ? NCTR : n_centres);
        for (int p = 0; p < NPTS; p++)
            owner[p] = '0;
        for (it = 0; it < pass_limit; it++)
        begin
            moved = 0;
            for (int c = 0; c < NCTR; c++)
            begin
                members[c] = 0;
                sum_x[c] = 0;
                sum_y[c] = 0;
            end
            for (int p = 0; p < np; p++)
            begin
                best = sq_dist(p, 0);
                bc = 0;
                for (int c = 1; c < nc; c++)
                begin
                    d = sq_dist(p, c);
                    if (d < best)
                    begin
                        best = d;
                        bc = c;
                    end
                end
                if (owner[p] != bc)
                begin
                    owner[p] = bc[3:0];
                    moved = 1;
                end
                sum_x[bc] += pt_x[p];
                sum_y[bc] += pt_y[p];
                members[bc]++;
            end
            for (int c = 0; c < nc; c++)
            begin
                if (members[c] != 0)
                begin
                    ctr_x[c] = shortint'(sum_x[c] / longint'(members[c]));
                    ctr_y[c] = shortint'(sum_y[c] / longint'(members[c]));
                end
            end
            if (!moved)
                break;
        end
        return it[15:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        answer_t want;
        answer_t got;
        if (!rst_n)
        begin
            for (int p = 0; p < NPTS; p++)
            begin
                pt_x[p] = 0;
                pt_y[p] = 0;
                owner[p] = '0;
            end
            for (int c = 0; c < NCTR; c++)
            begin
                ctr_x[c] = 0;
                ctr_y[c] = 0;
            end
            n_points = kmc_pkg::POINT_COUNT_RST;
            n_centres = kmc_pkg::CENTER_COUNT_RST;
            pass_limit = kmc_pkg::MAX_ITERATIONS_RST;
            answers.delete();
            error_count <= 0;
            awaited <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    kmc_pkg::REG_POINT_COUNT:    n_points = pwdata[10:0];
                    kmc_pkg::REG_CENTER_COUNT:   n_centres = pwdata[4:0];
                    kmc_pkg::REG_MAX_ITERATIONS: pass_limit = pwdata[15:0];
                    default: ;
                endcase
            end
            if (done)
            begin
                got = '{cluster, iterations_done, is_run_result};
                if (answers.size() == 0)
                begin
                    $error("unexpected result word: cluster %0d iterations %0d run %0b",
                           cluster, iterations_done, is_run_result);
                    error_count <= error_count + 1;
                end
                else
                begin
                    want = answers.pop_front();
                    if (got.cluster !== want.cluster)
                        $error("cluster: expected %0d, got %0d", want.cluster, got.cluster);
                    if (got.iters !== want.iters)
                        $error("iterations_done: expected %0d, got %0d",
                               want.iters, got.iters);
                    if (got.is_run !== want.is_run)
                        $error("is_run_result: expected %0b, got %0b",
                               want.is_run, got.is_run);
                    if (got.cluster !== want.cluster || got.iters !== want.iters ||
                        got.is_run !== want.is_run)
                        error_count <= error_count + 1;
                end
            end
            if (start && !busy)
            begin
                case (func)
                    kmc_pkg::FUNC_LOAD_POINT:
                    begin
                        pt_x[slot] = coord_x;
                        pt_y[slot] = coord_y;
                    end
                    kmc_pkg::FUNC_LOAD_CENTER:
                    begin
                        if (slot < NCTR)
                        begin
                            ctr_x[slot] = coord_x;
                            ctr_y[slot] = coord_y;
                        end
                    end
                    kmc_pkg::FUNC_RUN:
                        answers.push_back('{4'd0, cluster_points(), 1'b1});
                    default:
                        answers.push_back('{owner[slot], 16'd0, 1'b0});
                endcase
            end
            awaited <= answers.size();
        end
    end
endmodule

// ----- tb/kmeans_2d_clustering_unit_test.sv -----
`timescale 1ns / 1ps

module kmeans_2d_clustering_unit_test;

    localparam int QUIET_LIMIT = 400000;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        psel = 0;
    logic        penable = 0;
    logic        pwrite = 0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        start = 0;
    logic        busy;
    logic [1:0]  func = kmc_pkg::FUNC_LOAD_POINT;
    logic [9:0]  slot = '0;
    logic signed [15:0] coord_x = '0;
    logic signed [15:0] coord_y = '0;
    logic        done;
    logic [3:0]  cluster;
    logic [15:0] iterations_done;
    logic        is_run_result;
    int          error_count;
    int          awaited;
    int          quiet = 0;
    int          issued = 0;

    kmeans_2d_clustering_unit uut (.*);
    kmeans_2d_clustering_checker checker_i (.*);

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done || psel)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("kmeans_2d_clustering_unit_test: errors");
            $finish;
        end
    end

    task automatic issue(logic [1:0] f, int s, logic [15:0] x, logic [15:0] y);
        start <= 1;
        func <= f;
        slot <= s[9:0];
        coord_x <= x;
        coord_y <= y;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        issued++;
    endtask

    task automatic pause(int n);
        start <= 0;
        repeat (n) @(posedge clk);
    endtask

    task automatic settle();
        start <= 0;
        @(posedge clk);
        while (awaited != 0 || busy)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic cfg(logic [1:0] idx, int val);
        psel <= 1;
        pwrite <= 1;
        penable <= 0;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0;
        penable <= 0;
        @(posedge clk);
    endtask

    function automatic logic [15:0] pick_coord();
        if ($urandom_range(0, 1))
            return 16'($urandom);
        return 16'($urandom_range(0, 4095)) - 16'd2048 + 16'($urandom_range(0, 3) * 8000);
    endfunction

    initial
    begin
        int n;
        int r;
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // fill every slot a run can reach
        for (int i = 0; i < 28; i++)
        begin
            if (i == 0)
                issue(kmc_pkg::FUNC_LOAD_POINT, i, 16'h8000, 16'h8000);
            else if (i == 1)
                issue(kmc_pkg::FUNC_LOAD_POINT, i, 16'h7fff, 16'h7fff);
            else
                issue(kmc_pkg::FUNC_LOAD_POINT, i, pick_coord(), pick_coord());
        end
        for (int i = 0; i < 16; i++)
            issue(kmc_pkg::FUNC_LOAD_CENTER, i, pick_coord(), pick_coord());
        issue(kmc_pkg::FUNC_LOAD_CENTER, 16, 16'h7fff, 16'h8000);
        issue(kmc_pkg::FUNC_LOAD_CENTER, 1023, 16'h8000, 16'h7fff);
        issue(kmc_pkg::FUNC_READ, 5, 16'd0, 16'd0);
        settle();

        // saturating centre count, single pass
        cfg(kmc_pkg::REG_POINT_COUNT, 24);
        cfg(kmc_pkg::REG_CENTER_COUNT, 31);
        cfg(kmc_pkg::REG_MAX_ITERATIONS, 1);
        issue(kmc_pkg::FUNC_RUN, 0, 16'd0, 16'd0);
        issue(kmc_pkg::FUNC_READ, 0, 16'd0, 16'd0);
        issue(kmc_pkg::FUNC_READ, 1, 16'd0, 16'd0);
        issue(kmc_pkg::FUNC_READ, 1023, 16'd0, 16'd0);
        settle();
        cfg(kmc_pkg::REG_POINT_COUNT, 0);
        cfg(kmc_pkg::REG_MAX_ITERATIONS, 65535);
        issue(kmc_pkg::FUNC_RUN, 0, 16'd0, 16'd0);
        settle();
        cfg(kmc_pkg::REG_POINT_COUNT, 1);
        cfg(kmc_pkg::REG_CENTER_COUNT, 0);
        issue(kmc_pkg::FUNC_RUN, 0, 16'd0, 16'd0);
        settle();
        cfg(kmc_pkg::REG_POINT_COUNT, 8);
        cfg(kmc_pkg::REG_CENTER_COUNT, 4);
        cfg(kmc_pkg::REG_MAX_ITERATIONS, 0);
        issue(kmc_pkg::FUNC_RUN, 0, 16'd0, 16'd0);
        issue(kmc_pkg::FUNC_READ, 3, 16'd0, 16'd0);
        settle();

        // equal centres: ties go to the lower index
        cfg(kmc_pkg::REG_POINT_COUNT, 4);
        cfg(kmc_pkg::REG_CENTER_COUNT, 3);
        cfg(kmc_pkg::REG_MAX_ITERATIONS, 10);
        issue(kmc_pkg::FUNC_LOAD_CENTER, 0, 16'd100, 16'd100);
        issue(kmc_pkg::FUNC_LOAD_CENTER, 1, 16'd100, 16'd100);
        issue(kmc_pkg::FUNC_LOAD_CENTER, 2, -16'sd5000, 16'd0);
        for (int i = 0; i < 4; i++)
            issue(kmc_pkg::FUNC_LOAD_POINT, i, 16'(i * 60), -16'sd5000 * i[0]);
        issue(kmc_pkg::FUNC_RUN, 0, 16'd0, 16'd0);
        for (int i = 0; i < 4; i++)
            issue(kmc_pkg::FUNC_READ, i, 16'd0, 16'd0);
        settle();

        issued = 0;
        while (issued < 450)
        begin
            settle();
            r = $urandom_range(0, 9);
            cfg(kmc_pkg::REG_POINT_COUNT, (r == 0) ? 0 : $urandom_range(1, 24));
            cfg(kmc_pkg::REG_CENTER_COUNT, (r == 1) ? 0 : (r == 2) ? $urandom_range(16, 31)
                                                                   : $urandom_range(1, 8));
            cfg(kmc_pkg::REG_MAX_ITERATIONS, (r == 3) ? 1 : $urandom_range(0, 12));
            n = $urandom_range(10, 30);
            for (int k = 0; k < n; k++)
            begin
                r = $urandom_range(0, 99);
                if (r < 40)
                    issue(kmc_pkg::FUNC_LOAD_POINT, ($urandom_range(0, 7) == 0) ?
                          $urandom_range(0, 1023) : $urandom_range(0, 27),
                          pick_coord(), pick_coord());
                else if (r < 55)
                    issue(kmc_pkg::FUNC_LOAD_CENTER, ($urandom_range(0, 7) == 0) ?
                          $urandom_range(0, 1023) : $urandom_range(0, 15),
                          pick_coord(), pick_coord());
                else if (r < 66)
                    issue(kmc_pkg::FUNC_RUN, $urandom_range(0, 1023),
                          pick_coord(), pick_coord());
                else
                    issue(kmc_pkg::FUNC_READ, ($urandom_range(0, 7) == 0) ?
                          $urandom_range(0, 1023) : $urandom_range(0, 27),
                          pick_coord(), pick_coord());
                if (issued < 380 && $urandom_range(0, 5) == 0)
                    pause($urandom_range(1, 14));
            end
        end

        settle();
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("kmeans_2d_clustering_unit_test: clean");
        else
            $display("kmeans_2d_clustering_unit_test: errors");
        $finish;
    end
endmodule
